@@ hw/rtl/mbrm_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrm_pkg: shared types and constants
// Command/result payloads, op and status codes, CRC-16/Modbus byte step.
// ----------------------------------------------------------------------------
package mbrm_pkg;

  // op codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_BYTE  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // completion status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CRC_ERR  = 2'd2;
  localparam logic [1:0] ST_ECHO_ERR = 2'd3;

  // result kinds
  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_CPL = 1'b1;

  // config register indexes
  localparam logic CFG_DEVICE_ADDR   = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0]  DEVICE_ADDR_RST   = 8'd1;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] READ_COUNT      = 16'h0001;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] ERR_VALUE       = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] reg_addr;
    logic [15:0] write_value;
    logic [7:0]  rx_data;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_data;
    logic        last;
    logic [15:0] read_value;
    logic [1:0]  status;
  } rsp_t;

  // request header handed to the serializer at start
  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [15:0] word;
  } req_t;

  // serializer output toward the result register
  typedef struct packed {
    logic       busy;
    logic [7:0] data;
    logic       last;
  } tx_t;

  // one reflected CRC-16/Modbus byte step
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mbrm_req_tx.sv @@
// ----------------------------------------------------------------------------
// mbrm_req_tx: request serializer
// Shifts out request bytes 1..7 (byte 0 goes out at start), folds the CRC in
// one byte per step, and keeps a copy of all eight bytes for echo checking.
// ----------------------------------------------------------------------------
module mbrm_req_tx
  import mbrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  req_t       req,
  input  logic       advance,
  output tx_t        tx,
  input  logic [2:0] echo_idx,
  output logic [7:0] echo_byte
);

  logic       busy;
  logic [2:0] cnt;
  logic [39:0] shift;
  logic [15:0] crc;
  logic [7:0]  request_copy [8];

  always_comb begin
    tx.busy = busy;
    tx.last = 1'b0;
    case (cnt)
      3'd6: tx.data = crc[7:0];
      3'd7: begin
        tx.data = crc[15:8];
        tx.last = 1'b1;
      end
      default: tx.data = shift[39:32];
    endcase
  end

  assign echo_byte = request_copy[echo_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 3'd1;
    end else if (advance && busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      request_copy[0] <= req.dev_addr;
      request_copy[1] <= req.func;
      request_copy[2] <= req.reg_addr[15:8];
      request_copy[3] <= req.reg_addr[7:0];
      request_copy[4] <= req.word[15:8];
      request_copy[5] <= req.word[7:0];
      shift <= {req.func, req.reg_addr, req.word};
      crc   <= crc_byte(CRC_INIT, req.dev_addr);
    end else if (advance && busy) begin
      if (cnt <= 3'd5) begin
        crc   <= crc_byte(crc, shift[39:32]);
        shift <= {shift[31:0], 8'h00};
      end
      if (cnt == 3'd6) begin
        request_copy[6] <= crc[7:0];
      end
      if (cnt == 3'd7) begin
        request_copy[7] <= crc[15:8];
      end
    end
  end

endmodule

@@ hw/rtl/modbus_rtu_register_master_core.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_register_master_core: Modbus RTU single-register master
// Builds read/write requests, checks responses, times out on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (valid/ready) carries one item per transfer: start read,
//   start write, one received byte, or one timer tick.
//   rsp channel carries results: eight request bytes per start (the eighth
//   flagged last), then one completion with read_value and status.
//   cfg_we/cfg_index/cfg_data write device_addr (0) and timeout_ticks (1);
//   write only while no transaction is running.
// Latency/throughput:
//   A byte or tick item is handled when it transfers; its completion, if any,
//   is in the result register the cycle after the transfer. On a start,
//   byte 0 goes out the next cycle and the serializer emits one byte per
//   cycle after that while the result register is free, one CRC byte step
//   per cycle. cmd_ready is low while the serializer runs.
// Reset: synchronous, clears phase, counters and the result valid;
//   registers return to device_addr 1, timeout_ticks 100.
// Stall: a result waits in the output register; besides the serializer run,
//   cmd_ready drops when that register is full and not being taken this
//   cycle. A stalled serializer holds its byte until the register frees up.
// ----------------------------------------------------------------------------
module modbus_rtu_register_master_core
  import mbrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_READ  = 3'b010,
    PH_WRITE = 3'b100
  } phase_t;

  // config
  logic [7:0]  device_addr;
  logic [15:0] timeout_ticks;

  // transaction state
  phase_t      phase, phase_next;
  logic [8:0]  rx_index, rx_index_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] data_word, data_word_next;
  logic        echo_bad, echo_bad_next;
  logic [15:0] elapsed, elapsed_next;

  // handshake
  logic out_free;
  logic acc;
  logic is_start;

  // completion
  logic        cpl;
  logic [15:0] cpl_val;
  logic [1:0]  cpl_st;

  logic [16:0] tick_sum;
  logic [8:0]  span;
  logic        bad;

  req_t       req;
  tx_t        tx;
  logic [7:0] echo_byte;

  assign out_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = !tx.busy && out_free;
  assign acc       = cmd_valid && cmd_ready;
  assign is_start  = (cmd.op == OP_READ) || (cmd.op == OP_WRITE);

  assign req.dev_addr = device_addr;
  assign req.func     = (cmd.op == OP_WRITE) ? FN_WRITE_SINGLE : FN_READ_HOLDING;
  assign req.reg_addr = cmd.reg_addr;
  assign req.word     = (cmd.op == OP_WRITE) ? cmd.write_value : READ_COUNT;

  mbrm_req_tx u_req_tx (
    .clk       (clk),
    .rst       (rst),
    .start     (acc && is_start),
    .req       (req),
    .advance   (out_free),
    .tx        (tx),
    .echo_idx  (rx_index[2:0]),
    .echo_byte (echo_byte)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_addr   <= DEVICE_ADDR_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDR:   device_addr   <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-item update
  always_comb begin
    phase_next       = phase;
    rx_index_next    = rx_index;
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    data_word_next   = data_word;
    echo_bad_next    = echo_bad;
    elapsed_next     = elapsed;
    cpl     = 1'b0;
    cpl_val = 16'h0000;
    cpl_st  = ST_OK;
    bad     = echo_bad;
    tick_sum = {1'b0, elapsed} + 17'd1;
    span     = {1'b0, byte_count} + 9'd3;

    if (acc) begin
      if (is_start) begin
        phase_next       = (cmd.op == OP_WRITE) ? PH_WRITE : PH_READ;
        rx_index_next    = 9'd0;
        byte_count_next  = 8'd0;
        running_crc_next = CRC_INIT;
        data_word_next   = 16'h0000;
        echo_bad_next    = 1'b0;
        elapsed_next     = 16'h0000;
      end else if (phase != PH_IDLE) begin
        if (cmd.op == OP_TICK) begin
          // saturating tick count
          elapsed_next = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
          if (tick_sum >= {1'b0, timeout_ticks}) begin
            cpl        = 1'b1;
            cpl_val    = ERR_VALUE;
            cpl_st     = ST_TIMEOUT;
            phase_next = PH_IDLE;
          end
        end else if (phase == PH_WRITE) begin
          // echo must repeat the request byte for byte
          bad           = echo_bad || (echo_byte != cmd.rx_data);
          echo_bad_next = bad;
          rx_index_next = rx_index + 9'd1;
          if (rx_index[2:0] == 3'd7) begin
            cpl        = 1'b1;
            cpl_val    = bad ? ERR_VALUE : 16'h0000;
            cpl_st     = bad ? ST_ECHO_ERR : ST_OK;
            phase_next = PH_IDLE;
          end
        end else begin
          // read response: addr, func, count, data..., crc lo, crc hi
          if (rx_index == 9'd2) begin
            byte_count_next = cmd.rx_data;
          end
          if (rx_index == 9'd3) begin
            data_word_next = {cmd.rx_data, 8'h00};
          end
          if (rx_index == 9'd4) begin
            data_word_next = {data_word[15:8], cmd.rx_data};
          end
          if (rx_index < 9'd3 || rx_index < span) begin
            running_crc_next = crc_byte(running_crc, cmd.rx_data);
          end else if (rx_index == span) begin
            bad = echo_bad || (cmd.rx_data != running_crc[7:0]);
          end else begin
            bad        = echo_bad || (cmd.rx_data != running_crc[15:8]);
            cpl        = 1'b1;
            phase_next = PH_IDLE;
          end
          echo_bad_next = bad;
          rx_index_next = rx_index + 9'd1;
          cpl_val = bad ? ERR_VALUE : data_word_next;
          cpl_st  = bad ? ST_CRC_ERR : ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      rx_index    <= 9'd0;
      byte_count  <= 8'd0;
      running_crc <= CRC_INIT;
      data_word   <= 16'h0000;
      echo_bad    <= 1'b0;
      elapsed     <= 16'h0000;
    end else begin
      phase       <= phase_next;
      rx_index    <= rx_index_next;
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
      data_word   <= data_word_next;
      echo_bad    <= echo_bad_next;
      elapsed     <= elapsed_next;
    end
  end

  // result register: start byte 0, completion, or serializer byte
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((acc && (is_start || cpl)) || (tx.busy && out_free)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_start) begin
      rsp <= '{kind: KIND_TX, tx_data: device_addr, last: 1'b0,
               read_value: 16'h0000, status: ST_OK};
    end else if (acc && cpl) begin
      rsp <= '{kind: KIND_CPL, tx_data: 8'h00, last: 1'b0,
               read_value: cpl_val, status: cpl_st};
    end else if (tx.busy && out_free) begin
      rsp <= '{kind: KIND_TX, tx_data: tx.data, last: tx.last,
               read_value: 16'h0000, status: ST_OK};
    end
  end

endmodule

@@ hw/rtl/mbrm_checker.sv @@
// ----------------------------------------------------------------------------
// mbrm_checker: port-level checks for the register master
// Watches the cmd and rsp channels of the top level over time.
// ----------------------------------------------------------------------------
module mbrm_checker
  import mbrm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input cmd_t        cmd,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input rsp_t        rsp
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  // a start transfer puts the first request byte out next cycle
  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd.op == OP_READ || cmd.op == OP_WRITE)
    |=> rsp_valid && rsp.kind == KIND_TX && !rsp.last)
    else $error("start did not emit request byte");

  // no new command mid-request
  a_no_cmd_mid_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_TX && !rsp.last |-> !cmd_ready)
    else $error("cmd accepted during request serialization");

  // after the last request byte leaves, the next result is not another request
  // byte without a fresh start
  a_last_once: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && rsp.kind == KIND_TX && rsp.last &&
    !(cmd_valid && cmd_ready && (cmd.op == OP_READ || cmd.op == OP_WRITE))
    |=> !(rsp_valid && rsp.kind == KIND_TX))
    else $error("request byte after last without start");

endmodule

bind modbus_rtu_register_master_core mbrm_checker u_mbrm_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
